// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker in trs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define TRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trs check failed");

// Next-cycle implication, held off while reset is asserted.
`define TRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trs check failed");

`endif

// ===== hdl/trs_pkg.sv =====
package trs_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 512;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0]  MAX_TRIES_RST = 8'd5;
  localparam logic [15:0] FIRST_BLOCK   = 16'd1;
  localparam logic [7:0]  RETRY_SAT     = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_ZERO  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES = 1'b1;

  typedef enum logic [2:0] {
    KIND_START      = 3'd0,
    KIND_DATA       = 3'd1,
    KIND_REMOTE_ERR = 3'd2,
    KIND_OTHER_OP   = 3'd3,
    KIND_BAD_DGRAM  = 3'd4,
    KIND_TIMEOUT    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2,
    PH_FAIL = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    RSN_TRIES  = 3'd0,
    RSN_STORE  = 3'd1,
    RSN_BADBLK = 3'd2,
    RSN_NOTDAT = 3'd3,
    RSN_NOTMSG = 3'd4
  } reason_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] block_number;
    logic [9:0]  block_length;
    logic        store_failed;
  } item_t;

  // Packed so that send_ack lands in bit 0 and status in the top bits.
  typedef struct packed {
    phase_t      status;
    logic        store_block;
    reason_t     error_reason;
    logic        send_error;
    logic [15:0] ack_number;
    logic        send_ack;
  } result_t;

  typedef struct packed {
    logic       ack_zero;
    logic [7:0] max_tries;
  } cfg_t;

  // Handshake between the input stage, the sequencer and the result register.
  typedef struct packed {
    logic space;  // result register can load this cycle
    logic fire;   // held item moves into the result register
  } stage_ctl_t;

endpackage

// ===== hdl/tftp_receive_sequencer_unit.sv =====
// Channel   Direction  Transaction
// in_*      slave      one event: kind in tuser, block fields in tdata
// out_*     master     one result: ack, error, store and status flags
// cfg_*     write      one register write, no handshake
//
// One event per cycle sustained while out_tready stays high; each result passes
// through the input register, then the result register, before it shows on out_*.
// Both stages hold while the result register is full and out_tready is low;
// in_tready drops only then, so the input side never waits on an idle result side.
// rst_n is synchronous and active low: it empties both stages, sets the
// expected block to 1, clears the retry count and returns the phase to idle.
module tftp_receive_sequencer_unit #(
  parameter int unsigned BLOCK_BYTES = trs_pkg::BLOCK_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: block_number[15:0], block_length[25:16], store_failed[26], zero pad
  input  logic [trs_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: kind[2:0]
  input  logic [trs_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: send_ack[0], ack_number[16:1], send_error[17], error_reason[20:18],
  //        store_block[21], status[23:22]
  output logic [trs_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic [trs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  trs_pkg::cfg_t       cfg_r;
  trs_pkg::item_t      in_item;
  trs_pkg::item_t      item;
  trs_pkg::stage_ctl_t ctl;
  trs_pkg::result_t    res;
  trs_pkg::result_t    out_res;
  logic                space;

  // Unpack the incoming transaction; the pad bits above store_failed are dropped.
  assign in_item.kind         = trs_pkg::kind_t'(in_tuser);
  assign in_item.block_number = in_tdata[15:0];
  assign in_item.block_length = in_tdata[25:16];
  assign in_item.store_failed = in_tdata[26];

  assign out_tdata = out_res;

  // Configuration registers; the user must write them only while the block is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_zero  <= 1'b0;
      cfg_r.max_tries <= trs_pkg::MAX_TRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trs_pkg::CFG_ACK_ZERO:  cfg_r.ack_zero  <= cfg_wdata[0];
        trs_pkg::CFG_MAX_TRIES: cfg_r.max_tries <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted event until the result register has room.
  trs_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .space     (space),
    .ctl       (ctl),
    .item      (item)
  );

  // Decide the result and advance the transfer state as the event moves on.
  trs_engine #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .ctl   (ctl),
    .item  (item),
    .res   (res)
  );

  // Present the result until the downstream side takes it.
  trs_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

endmodule

// ===== hdl/trs_in_stage.sv =====
module trs_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  trs_pkg::item_t      in_item,
  input  logic                space,
  output trs_pkg::stage_ctl_t ctl,
  output trs_pkg::item_t      item
);

  logic           valid_r;
  logic           valid_nxt;
  trs_pkg::item_t item_r;
  logic           take;

  assign ctl.space = space;
  assign ctl.fire  = valid_r && space;
  assign in_tready = !valid_r || space;
  assign take      = in_tvalid && in_tready;
  assign item      = item_r;

  always_comb begin
    priority if (take) begin
      valid_nxt = 1'b1;
    end else if (ctl.fire) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== hdl/trs_engine.sv =====
module trs_engine #(
  parameter int unsigned BLOCK_BYTES = trs_pkg::BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  trs_pkg::cfg_t       cfg,
  input  trs_pkg::stage_ctl_t ctl,
  input  trs_pkg::item_t      item,
  output trs_pkg::result_t    res
);

  localparam logic [16:0] BlockBytesW = 17'(BLOCK_BYTES);

  logic [15:0]       expected_r;
  logic [15:0]       expected_nxt;
  logic [7:0]        retry_r;
  logic [7:0]        retry_nxt;
  trs_pkg::phase_t   phase_r;
  trs_pkg::phase_t   phase_nxt;

  logic [15:0] diff;
  logic [7:0]  retry_inc;
  logic        tries_hit;
  logic        is_short;

  assign diff      = expected_r - item.block_number;
  assign retry_inc = (retry_r == trs_pkg::RETRY_SAT) ? retry_r : retry_r + 8'd1;
  assign tries_hit = retry_inc >= cfg.max_tries;
  assign is_short  = {7'd0, item.block_length} < BlockBytesW;

  always_comb begin
    res          = '0;
    expected_nxt = expected_r;
    retry_nxt    = retry_r;
    phase_nxt    = phase_r;
    priority if (item.kind == trs_pkg::KIND_START) begin
      expected_nxt = trs_pkg::FIRST_BLOCK;
      retry_nxt    = '0;
      phase_nxt    = trs_pkg::PH_RUN;
      res.send_ack = cfg.ack_zero;
    end else if (phase_r == trs_pkg::PH_RUN) begin
      unique case (item.kind)
        trs_pkg::KIND_DATA: begin
          priority if (diff == 16'd0) begin
            if (item.store_failed) begin
              res.send_error   = 1'b1;
              res.error_reason = trs_pkg::RSN_STORE;
              phase_nxt        = trs_pkg::PH_FAIL;
            end else begin
              res.store_block = 1'b1;
              res.send_ack    = 1'b1;
              res.ack_number  = expected_r;
              if (is_short) begin
                phase_nxt = trs_pkg::PH_DONE;
              end else begin
                retry_nxt    = '0;
                expected_nxt = expected_r + 16'd1;
              end
            end
          end else if (diff == 16'd1) begin
            // Repeat of the previous block: ack it again, count a retry.
            res.send_ack   = 1'b1;
            res.ack_number = expected_r - 16'd1;
            retry_nxt      = retry_inc;
            if (tries_hit) begin
              res.send_error   = 1'b1;
              res.error_reason = trs_pkg::RSN_TRIES;
              phase_nxt        = trs_pkg::PH_FAIL;
            end
          end else begin
            res.send_error   = 1'b1;
            res.error_reason = trs_pkg::RSN_BADBLK;
            phase_nxt        = trs_pkg::PH_FAIL;
          end
        end
        trs_pkg::KIND_REMOTE_ERR: begin
          phase_nxt = trs_pkg::PH_FAIL;
        end
        trs_pkg::KIND_OTHER_OP: begin
          res.send_error   = 1'b1;
          res.error_reason = trs_pkg::RSN_NOTDAT;
          phase_nxt        = trs_pkg::PH_FAIL;
        end
        trs_pkg::KIND_BAD_DGRAM: begin
          res.send_error   = 1'b1;
          res.error_reason = trs_pkg::RSN_NOTMSG;
          phase_nxt        = trs_pkg::PH_FAIL;
        end
        trs_pkg::KIND_TIMEOUT: begin
          retry_nxt = retry_inc;
          if (tries_hit) begin
            res.send_error   = 1'b1;
            res.error_reason = trs_pkg::RSN_TRIES;
            phase_nxt        = trs_pkg::PH_FAIL;
          end
        end
        default: begin
        end
      endcase
    end else begin
      // Not running and not a start: drop the event, hold the state.
    end
    res.status = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= trs_pkg::FIRST_BLOCK;
      retry_r    <= '0;
      phase_r    <= trs_pkg::PH_IDLE;
    end else if (ctl.fire) begin
      expected_r <= expected_nxt;
      retry_r    <= retry_nxt;
      phase_r    <= phase_nxt;
    end
  end

endmodule

// ===== hdl/trs_out_reg.sv =====
module trs_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  trs_pkg::stage_ctl_t ctl,
  input  trs_pkg::result_t    res,
  output logic                space,
  output logic                out_tvalid,
  input  logic                out_tready,
  output trs_pkg::result_t    out_res
);

  logic             valid_r;
  logic             valid_nxt;
  trs_pkg::result_t res_r;

  assign space      = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_comb begin
    priority if (ctl.fire) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      res_r <= res;
    end
  end

endmodule

// ===== hdl/trs_checker.sv =====
`include "assert_macros.svh"

module trs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [trs_pkg::OUT_DATA_W-1:0] out_tdata
);

  trs_pkg::result_t res;

  assign res = out_tdata;

  // A stalled result stays put.
  `TRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Every error sent to the peer ends the transfer as failed.
  `TRS_ASSERT_IMP(a_err_fails, clk, rst_n, out_tvalid && res.send_error, res.status == trs_pkg::PH_FAIL)

  // A stored block is always acknowledged.
  `TRS_ASSERT_IMP(a_store_acks, clk, rst_n, out_tvalid && res.store_block, res.send_ack && res.status != trs_pkg::PH_FAIL)

  // No error sent means the reason field is clear.
  `TRS_ASSERT_IMP(a_rsn_clear, clk, rst_n, out_tvalid && !res.send_error, res.error_reason == trs_pkg::RSN_TRIES)

  // No ack sent means the ack number is clear.
  `TRS_ASSERT_IMP(a_ackn_clear, clk, rst_n, out_tvalid && !res.send_ack, res.ack_number == 16'd0)

endmodule

bind tftp_receive_sequencer_unit trs_checker u_trs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tftp_receive_sequencer_unit_checker.sv =====
module tftp_receive_sequencer_unit_checker #(
  parameter int unsigned BLOCK_BYTES = trs_pkg::BLOCK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [trs_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [trs_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [trs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_we,
  input  logic [trs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              mismatches,
  output int                              pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import trs_pkg::*;

  // Shadow of the sequencer state and its registers.
  logic        ack_zero_q;
  logic [7:0]  max_tries_q;
  logic [15:0] next_block;
  logic [7:0]  retry_tally;
  phase_t      xfer_phase;

  result_t     awaited_results[$];

  task automatic report_mismatch(input string note);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, note);
  endtask

  function automatic void fail_transfer(inout result_t res, input reason_t why);
    res.send_error   = 1'b1;
    res.error_reason = why;
    xfer_phase       = PH_FAIL;
  endfunction

  // Repeat blocks and timeouts both land here.
  function automatic void bump_retry(inout result_t res);
    if (retry_tally < RETRY_SAT) begin
      retry_tally++;
    end
    if (retry_tally >= max_tries_q) begin
      fail_transfer(res, RSN_TRIES);
    end
  endfunction

  function automatic result_t sequence_event(input logic [2:0]  kind,
                                             input logic [15:0] bnum,
                                             input logic [9:0]  blen,
                                             input logic        sfail);
    result_t     res;
    logic [15:0] distance;
    res = '0;
    if (kind == KIND_START) begin
      next_block   = FIRST_BLOCK;
      retry_tally  = '0;
      xfer_phase   = PH_RUN;
      res.send_ack = ack_zero_q;
    end else if (xfer_phase == PH_RUN && kind <= KIND_TIMEOUT) begin
      case (kind)
        KIND_DATA: begin
          distance = next_block - bnum;
          if (distance == 16'd0) begin
            if (sfail) begin
              fail_transfer(res, RSN_STORE);
            end else begin
              res.store_block = 1'b1;
              res.send_ack    = 1'b1;
              res.ack_number  = next_block;
              if (32'(blen) < BLOCK_BYTES) begin
                xfer_phase = PH_DONE;
              end else begin
                retry_tally = '0;
                next_block  = next_block + 16'd1;
              end
            end
          end else if (distance == 16'd1) begin
            res.send_ack   = 1'b1;
            res.ack_number = next_block - 16'd1;
            bump_retry(res);
          end else begin
            fail_transfer(res, RSN_BADBLK);
          end
        end
        KIND_REMOTE_ERR: xfer_phase = PH_FAIL;
        KIND_OTHER_OP:   fail_transfer(res, RSN_NOTDAT);
        KIND_BAD_DGRAM:  fail_transfer(res, RSN_NOTMSG);
        default:         bump_retry(res);
      endcase
    end
    res.status = xfer_phase;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      ack_zero_q  = 1'b0;
      max_tries_q = MAX_TRIES_RST;
      next_block  = FIRST_BLOCK;
      retry_tally = '0;
      xfer_phase  = PH_IDLE;
      mismatches  = 0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACK_ZERO:  ack_zero_q  = cfg_wdata[0];
          CFG_MAX_TRIES: max_tries_q = cfg_wdata;
          default: ;
        endcase
      end
      // Results leave in event order, so check the oldest first.
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result 0x%06h with nothing awaited", out_tdata));
        end else begin
          want = awaited_results.pop_front();
          if (got.send_ack !== want.send_ack)
            report_mismatch($sformatf("send_ack expected %0d got %0d",
                                      want.send_ack, got.send_ack));
          if (got.ack_number !== want.ack_number)
            report_mismatch($sformatf("ack_number expected %0d got %0d",
                                      want.ack_number, got.ack_number));
          if (got.send_error !== want.send_error)
            report_mismatch($sformatf("send_error expected %0d got %0d",
                                      want.send_error, got.send_error));
          if (got.error_reason !== want.error_reason)
            report_mismatch($sformatf("error_reason expected %0d got %0d",
                                      want.error_reason, got.error_reason));
          if (got.store_block !== want.store_block)
            report_mismatch($sformatf("store_block expected %0d got %0d",
                                      want.store_block, got.store_block));
          if (got.status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, got.status));
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(sequence_event(in_tuser, in_tdata[15:0],
                                                 in_tdata[25:16], in_tdata[26]));
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

// ===== tb/tftp_receive_sequencer_unit_test.sv =====
module tftp_receive_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import trs_pkg::*;

  // Kind codes outside the defined set; the block must ignore them.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int          RAND_PHASES   = 6;
  localparam int          PHASE_ITEMS   = 120;
  localparam int          SETTLE_CYCLES = 6;     // pipeline is two stages deep
  localparam int          LONG_HOLD     = 300;   // receiver hold-off for backpressure
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic [IN_USER_W-1:0]   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int                     mismatches;
  int                     pending_results;
  int                     items_sent = 0;
  int unsigned            cycle_count = 0;

  // Idle control for the sender and the receiver.
  bit                     tx_steady = 1'b0;
  bit                     rx_steady = 1'b0;
  bit                     sink_hold_req = 1'b0;

  // Register settings for the random phases, extremes included.
  bit          phase_ack   [RAND_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  logic [7:0]  phase_tries [RAND_PHASES] = '{8'd5, 8'd3, 8'd1, 8'd255, 8'd2, 8'd0};

  tftp_receive_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  tftp_receive_sequencer_unit_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idle length: mostly a few cycles, now and then a long one.
  function automatic int random_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result sink. Drive out_tready once per falling edge; a long hold-off
  // requested by the stimulus is counted down here.
  initial begin : result_sink
    int stall_left;
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_tready <= 1'b0;
        stall_left = LONG_HOLD - 1;
      end else if (rx_steady || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = random_span() - 1;
      end
    end
  end

  // Offer one event and hold it until the block takes it. Called and
  // returns at a falling edge, so the next call drives in_tvalid once.
  task automatic send_event(input logic [2:0]  kind,
                            input logic [15:0] bnum,
                            input logic [9:0]  blen,
                            input logic        sfail);
    int gap;
    gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : random_span();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'd0, sfail, blen, bnum};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Any event with fully random fields, spare kind codes included.
  task automatic send_noise();
    send_event(3'($urandom_range(0, 7)), 16'($urandom), 10'($urandom_range(0, 1023)),
               1'($urandom));
  endtask

  // Stop offering and wait until every awaited result has come out.
  task automatic settle_results();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic set_config(input logic ack, input logic [7:0] tries);
    settle_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACK_ZERO;
    cfg_wdata <= {7'd0, ack};
    @(negedge clk);
    cfg_index <= CFG_MAX_TRIES;
    cfg_wdata <= tries;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One well-formed transfer with random content: start, full blocks with
  // the occasional repeat, timeout, store failure or stray event mixed in,
  // and a short block to close it.
  task automatic run_transfer();
    int          blocks;
    int          pick;
    logic [15:0] bnum;
    logic [9:0]  full_len;
    blocks = $urandom_range(1, 10);
    bnum   = FIRST_BLOCK;
    send_event(KIND_START, 16'($urandom), 10'($urandom_range(0, 1023)), 1'($urandom));
    for (int i = 0; i < blocks; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_event(KIND_DATA, bnum - 16'd1, 10'($urandom_range(0, 1023)), 1'b0);
      end else if (pick < 16) begin
        send_event(KIND_TIMEOUT, 16'($urandom), 10'($urandom_range(0, 1023)),
                   1'($urandom));
      end else if (pick < 21) begin
        send_noise();
      end else if (pick < 24) begin
        send_event(KIND_DATA, bnum, 10'($urandom_range(0, 1023)), 1'b1);
      end
      if (i == blocks - 1) begin
        send_event(KIND_DATA, bnum, 10'($urandom_range(0, BLOCK_BYTES_DEF - 1)), 1'b0);
      end else begin
        full_len = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(513, 1023)) : 10'd512;
        send_event(KIND_DATA, bnum, full_len, 1'b0);
        bnum = bnum + 16'd1;
      end
    end
  endtask

  initial begin : stimulus
    int base;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed events on the register values left by reset.
    send_event(KIND_SPARE_LO, 16'hFFFF, 10'h3FF, 1'b1);  // spare kind while idle
    send_event(KIND_DATA, FIRST_BLOCK, 10'd512, 1'b0);   // data while idle
    send_event(KIND_START, 16'd0, 10'd0, 1'b0);
    send_event(KIND_DATA, 16'd1, 10'd512, 1'b0);
    send_event(KIND_DATA, 16'd1, 10'd512, 1'b0);         // repeat of previous block
    send_event(KIND_TIMEOUT, 16'd0, 10'd0, 1'b0);
    send_event(KIND_DATA, 16'd2, 10'd1023, 1'b0);        // oversize counts as full
    send_event(KIND_START, 16'hFFFF, 10'h3FF, 1'b1);     // restart while running
    send_event(KIND_DATA, 16'd1, 10'd513, 1'b0);
    send_event(KIND_DATA, 16'd2, 10'd0, 1'b0);           // short block completes
    send_event(KIND_SPARE_HI, 16'd2, 10'd0, 1'b0);       // ignored once done
    send_event(KIND_TIMEOUT, 16'd0, 10'd0, 1'b0);        // ignored once done
    send_event(KIND_START, 16'd0, 10'd0, 1'b0);          // restart from completed
    send_event(KIND_DATA, 16'hFFFF, 10'd512, 1'b0);      // wrong block number
    send_event(KIND_START, 16'd0, 10'd0, 1'b0);
    send_event(KIND_REMOTE_ERR, 16'd0, 10'd0, 1'b0);
    send_event(KIND_START, 16'd0, 10'd0, 1'b0);
    send_event(KIND_OTHER_OP, 16'd1, 10'd512, 1'b0);
    send_event(KIND_START, 16'd0, 10'd0, 1'b0);
    send_event(KIND_BAD_DGRAM, 16'd1, 10'd512, 1'b0);
    send_event(KIND_START, 16'd0, 10'd0, 1'b0);
    send_event(KIND_DATA, 16'd1, 10'd511, 1'b1);         // store failure
    send_event(KIND_START, 16'd0, 10'd0, 1'b0);
    send_event(KIND_DATA, 16'd0, 10'd512, 1'b0);         // repeat of block zero
    repeat (4) send_event(KIND_TIMEOUT, 16'd0, 10'd0, 1'b0);  // hit the retry limit

    // Retry limit on a repeat block: ack and error in one result.
    set_config(1'b1, 8'd1);
    send_event(KIND_START, 16'd0, 10'd0, 1'b0);
    send_event(KIND_DATA, 16'd1, 10'd512, 1'b0);
    send_event(KIND_DATA, 16'd1, 10'd512, 1'b0);

    // A limit of zero fails on the first retry.
    set_config(1'b0, 8'd0);
    send_event(KIND_START, 16'd0, 10'd0, 1'b0);
    send_event(KIND_TIMEOUT, 16'd0, 10'd0, 1'b0);

    // Lower the limit below the count mid-transfer; next retry fails.
    set_config(1'b0, 8'd10);
    send_event(KIND_START, 16'd0, 10'd0, 1'b0);
    repeat (3) send_event(KIND_TIMEOUT, 16'd0, 10'd0, 1'b0);
    set_config(1'b0, 8'd2);
    send_event(KIND_TIMEOUT, 16'd0, 10'd0, 1'b0);

    // Random phases, one register setting each.
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_config(phase_ack[p], phase_tries[p]);
      rx_steady = ($urandom_range(0, 3) == 0);
      base = items_sent;
      if (p == 2) begin
        // Hold the receiver off while events keep coming back to back,
        // so both stages fill and in_tready drops.
        sink_hold_req = 1'b1;
        tx_steady     = 1'b1;
        repeat (3) run_transfer();
        tx_steady     = 1'b0;
      end
      while (items_sent - base < PHASE_ITEMS) begin
        tx_steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0) begin
          send_noise();
        end else begin
          run_transfer();
        end
        if ($urandom_range(0, 9) == 0) begin
          settle_results();
        end
      end
      tx_steady = 1'b0;
    end

    settle_results();
    if (mismatches == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
